### rtl/core/sfla_pkg.sv
// Shared types and constants for the sorted free-list handle allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package sfla_pkg;

  localparam int MODE_W     = 2;
  localparam int HANDLE_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int POOL_DEPTH_DEF = 4096;
  localparam int CAP_RESET      = 4096;

  localparam logic [HANDLE_W-1:0] BASE_RESET = 32'd1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HANDLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_WR,
    ST_FREE_CHK,
    ST_QUERY,
    ST_WALK,
    ST_LINK_PREV,
    ST_RESULT
  } sfla_state_t;

endpackage

### rtl/core/sfla_in_if.sv
// Request channel: valid/ready handshake with mode and handle payload.
// Depends on sfla_pkg for the field widths.
interface sfla_in_if;
  logic                             valid;
  logic                             ready;
  logic [sfla_pkg::MODE_W-1:0]      mode;
  logic [sfla_pkg::HANDLE_W-1:0]    handle;

  modport source (output valid, output mode, output handle, input ready);
  modport sink   (input valid, input mode, input handle, output ready);
endinterface

### rtl/core/sfla_out_if.sv
// Result channel: valid/ready handshake with the allocator's result fields.
// Depends on sfla_pkg for the field widths.
interface sfla_out_if;
  logic                             valid;
  logic                             ready;
  logic [sfla_pkg::HANDLE_W-1:0]    handle_out;
  logic [sfla_pkg::STATUS_W-1:0]    status;
  logic                             in_use;
  logic                             became_full;
  logic                             became_not_full;

  modport source (output valid, output handle_out, output status, output in_use,
                  output became_full, output became_not_full, input ready);
  modport sink   (input valid, input handle_out, input status, input in_use,
                  input became_full, input became_not_full, output ready);
endinterface

### rtl/core/sorted_free_list_handle_allocator_top.sv
// A request turned away at once (empty pool, handle out of range, unused mode) goes straight
// to the result; allocate, query or a free first read a slot, and a free of a used slot then
// walks the sorted list and, unless it becomes the new head, links its predecessor. One request
// at a time; ready returns as the result is registered, and a result held in the output
// register blocks the one after. Reset: synchronous, active low, then a clearing pass over all
// POOL_DEPTH slots (no requests taken); a capacity write starts the same pass.
module sorted_free_list_handle_allocator_top #(
  parameter int POOL_DEPTH = sfla_pkg::POOL_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sfla_in_if.sink                             in_chan,
  sfla_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfla_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW      = $clog2(POOL_DEPTH);
  localparam int IDXW    = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W   = (sfla_pkg::CAP_W > IDXW) ? sfla_pkg::CAP_W : IDXW;
  localparam int CAP_RST = (sfla_pkg::CAP_RESET > POOL_DEPTH) ? POOL_DEPTH
                                                              : sfla_pkg::CAP_RESET;
  localparam logic [IDXW-1:0] NO_INDEX = IDXW'(POOL_DEPTH);
  localparam logic [AW-1:0]   CLR_LAST = AW'(POOL_DEPTH - 1);

  sfla_pkg::sfla_state_t state_r, state_nxt;

  logic [AW-1:0]                      clr_r, clr_nxt;
  logic [sfla_pkg::HANDLE_W-1:0]      base_r, base_nxt;
  logic [IDXW-1:0]                    cap_r, cap_nxt;
  logic [IDXW-1:0]                    head_r, head_nxt;
  logic [IDXW-1:0]                    used_r, used_nxt;
  logic [IDXW-1:0]                    hint_r, hint_nxt;
  logic [IDXW-1:0]                    idx_r, idx_nxt;
  logic [IDXW-1:0]                    cur_r, cur_nxt;
  logic [IDXW-1:0]                    prev_r, prev_nxt;
  logic                               first_r, first_nxt;

  logic [sfla_pkg::HANDLE_W-1:0]      res_handle_r, res_handle_nxt;
  logic [sfla_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic                               res_in_use_r, res_in_use_nxt;
  logic                               res_full_r, res_full_nxt;
  logic                               res_notfull_r, res_notfull_nxt;

  logic                               out_valid_r;
  logic [sfla_pkg::HANDLE_W-1:0]      out_handle_r;
  logic [sfla_pkg::STATUS_W-1:0]      out_status_r;
  logic                               out_in_use_r;
  logic                               out_full_r;
  logic                               out_notfull_r;

  // Slot memory: {free bit, next link}
  logic [IDXW:0]                      mem_q [POOL_DEPTH];
  logic [IDXW:0]                      mem_rdata_r;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [IDXW:0]                      wr_data;

  logic                               accept;
  logic                               out_load;
  logic [sfla_pkg::HANDLE_W-1:0]      idx32;
  logic                               in_range;
  logic                               head_ok;
  logic [IDXW-1:0]                    rd_link;
  logic                               rd_free;
  logic [IDXW-1:0]                    cur_c;
  logic                               walk_go;
  logic [IDXW-1:0]                    start_c;
  logic [CMP_W-1:0]                   cap_wr_ext;
  logic [IDXW-1:0]                    cap_wr_eff;

  assign accept    = in_chan.valid && in_chan.ready;
  assign out_load  = (state_r == sfla_pkg::ST_RESULT) && (!out_valid_r || out_chan.ready);
  assign idx32     = in_chan.handle - base_r;
  assign in_range  = idx32 < sfla_pkg::HANDLE_W'(cap_r);
  assign head_ok   = head_r < cap_r;
  assign rd_link   = mem_rdata_r[IDXW-1:0];
  assign rd_free   = mem_rdata_r[IDXW];
  assign cur_c     = first_r ? cur_r : rd_link;
  assign walk_go   = (cur_c < cap_r) && (cur_c < idx_r);
  assign start_c   = ((hint_r < cap_r) && (idx_r > hint_r)) ? hint_r : head_r;

  // Clamp a written capacity into 1..POOL_DEPTH
  assign cap_wr_ext = CMP_W'(cfg_wdata[sfla_pkg::CAP_W-1:0]);
  always_comb begin
    if (cap_wr_ext == '0) begin
      cap_wr_eff = IDXW'(1);
    end else if (cap_wr_ext > CMP_W'(POOL_DEPTH)) begin
      cap_wr_eff = NO_INDEX;
    end else begin
      cap_wr_eff = cap_wr_ext[IDXW-1:0];
    end
  end

  assign in_chan.ready            = (state_r == sfla_pkg::ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.handle_out      = out_handle_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.in_use          = out_in_use_r;
  assign out_chan.became_full     = out_full_r;
  assign out_chan.became_not_full = out_notfull_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfla_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = sfla_pkg::ST_IDLE;
      end
      sfla_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_chan.mode)
            sfla_pkg::MODE_ALLOC:
              state_nxt = head_ok ? sfla_pkg::ST_ALLOC_WR : sfla_pkg::ST_RESULT;
            sfla_pkg::MODE_FREE:
              state_nxt = in_range ? sfla_pkg::ST_FREE_CHK : sfla_pkg::ST_RESULT;
            sfla_pkg::MODE_QUERY:
              state_nxt = in_range ? sfla_pkg::ST_QUERY : sfla_pkg::ST_RESULT;
            default:
              state_nxt = sfla_pkg::ST_RESULT;
          endcase
        end
      end
      sfla_pkg::ST_ALLOC_WR: state_nxt = sfla_pkg::ST_RESULT;
      sfla_pkg::ST_QUERY:    state_nxt = sfla_pkg::ST_RESULT;
      sfla_pkg::ST_FREE_CHK: begin
        state_nxt = rd_free ? sfla_pkg::ST_RESULT : sfla_pkg::ST_WALK;
      end
      sfla_pkg::ST_WALK: begin
        if (!walk_go) begin
          state_nxt = (prev_r == NO_INDEX) ? sfla_pkg::ST_RESULT : sfla_pkg::ST_LINK_PREV;
        end
      end
      sfla_pkg::ST_LINK_PREV: state_nxt = sfla_pkg::ST_RESULT;
      sfla_pkg::ST_RESULT: begin
        if (out_load) state_nxt = sfla_pkg::ST_IDLE;
      end
      default: state_nxt = sfla_pkg::ST_IDLE;
    endcase
    // A capacity write rebuilds the pool
    if (cfg_we && (cfg_index == sfla_pkg::CFG_CAPACITY)) state_nxt = sfla_pkg::ST_CLEAR;
  end

  // Memory control and datapath
  always_comb begin
    clr_nxt         = clr_r;
    base_nxt        = base_r;
    cap_nxt         = cap_r;
    head_nxt        = head_r;
    used_nxt        = used_r;
    hint_nxt        = hint_r;
    idx_nxt         = idx_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    first_nxt       = first_r;
    res_handle_nxt  = res_handle_r;
    res_status_nxt  = res_status_r;
    res_in_use_nxt  = res_in_use_r;
    res_full_nxt    = res_full_r;
    res_notfull_nxt = res_notfull_r;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;

    unique case (state_r)
      sfla_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = {1'b1, IDXW'(clr_r) + IDXW'(1)};
        clr_nxt = clr_r + AW'(1);
      end
      sfla_pkg::ST_IDLE: begin
        if (accept) begin
          res_handle_nxt  = '0;
          res_status_nxt  = sfla_pkg::STATUS_OK;
          res_in_use_nxt  = 1'b0;
          res_full_nxt    = 1'b0;
          res_notfull_nxt = 1'b0;
          idx_nxt         = idx32[IDXW-1:0];
          unique case (in_chan.mode)
            sfla_pkg::MODE_ALLOC: begin
              if (head_ok) begin
                rd_en   = 1'b1;
                rd_addr = head_r[AW-1:0];
              end else begin
                res_status_nxt = sfla_pkg::STATUS_EMPTY;
              end
            end
            sfla_pkg::MODE_FREE: begin
              if (in_range) begin
                rd_en   = 1'b1;
                rd_addr = idx32[AW-1:0];
              end else begin
                res_status_nxt = sfla_pkg::STATUS_IGNORED;
              end
            end
            sfla_pkg::MODE_QUERY: begin
              if (in_range) begin
                rd_en   = 1'b1;
                rd_addr = idx32[AW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      sfla_pkg::ST_ALLOC_WR: begin
        // Pop the head; its link becomes the new head
        wr_en          = 1'b1;
        wr_addr        = head_r[AW-1:0];
        wr_data        = {1'b0, rd_link};
        head_nxt       = rd_link;
        used_nxt       = used_r + IDXW'(1);
        res_full_nxt   = ((used_r + IDXW'(1)) == cap_r);
        res_handle_nxt = base_r + sfla_pkg::HANDLE_W'(head_r);
        if (hint_r == head_r) hint_nxt = NO_INDEX;
      end
      sfla_pkg::ST_FREE_CHK: begin
        if (rd_free) begin
          res_status_nxt = sfla_pkg::STATUS_IGNORED;
        end else begin
          res_notfull_nxt = (used_r == cap_r);
          hint_nxt        = idx_r;
          cur_nxt         = start_c;
          prev_nxt        = NO_INDEX;
          first_nxt       = 1'b1;
          if (used_r != '0) used_nxt = used_r - IDXW'(1);
        end
      end
      sfla_pkg::ST_WALK: begin
        if (walk_go) begin
          // Advance one link per cycle
          rd_en     = 1'b1;
          rd_addr   = cur_c[AW-1:0];
          prev_nxt  = cur_c;
          first_nxt = 1'b0;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r[AW-1:0];
          if (prev_r == NO_INDEX) begin
            wr_data  = {1'b1, head_ok ? head_r : NO_INDEX};
            head_nxt = idx_r;
          end else begin
            wr_data = {1'b1, cur_c};
          end
        end
      end
      sfla_pkg::ST_LINK_PREV: begin
        wr_en   = 1'b1;
        wr_addr = prev_r[AW-1:0];
        wr_data = {1'b1, idx_r};
      end
      sfla_pkg::ST_QUERY: begin
        res_in_use_nxt = !rd_free;
      end
      sfla_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        sfla_pkg::CFG_BASE_HANDLE: base_nxt = cfg_wdata;
        sfla_pkg::CFG_CAPACITY: begin
          cap_nxt  = cap_wr_eff;
          clr_nxt  = '0;
          head_nxt = '0;
          used_nxt = '0;
          hint_nxt = NO_INDEX;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfla_pkg::ST_CLEAR;
      clr_r   <= '0;
      base_r  <= sfla_pkg::BASE_RESET;
      cap_r   <= IDXW'(CAP_RST);
      head_r  <= '0;
      used_r  <= '0;
      hint_r  <= NO_INDEX;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      base_r  <= base_nxt;
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      used_r  <= used_nxt;
      hint_r  <= hint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    first_r       <= first_nxt;
    res_handle_r  <= res_handle_nxt;
    res_status_r  <= res_status_nxt;
    res_in_use_r  <= res_in_use_nxt;
    res_full_r    <= res_full_nxt;
    res_notfull_r <= res_notfull_nxt;
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_handle_r  <= res_handle_r;
      out_status_r  <= res_status_r;
      out_in_use_r  <= res_in_use_r;
      out_full_r    <= res_full_r;
      out_notfull_r <= res_notfull_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_rdata_r <= mem_q[rd_addr];
  end

`ifndef SYNTH
  a_used_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= cap_r)
    else $error("used count above capacity");

  a_full_means_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == cap_r) |-> (head_r >= cap_r))
    else $error("pool full but free list not empty");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("request taken while previous one in progress");

  a_empty_has_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (res_status_r != sfla_pkg::STATUS_OK)) |-> (res_handle_r == '0))
    else $error("handle returned with failing status");
`endif

endmodule
